[hdl/prs_pkg.sv]
// Shared widths, register indexes, command and status types for the resampler.
package prs_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned STEP_W = 21;
	localparam int unsigned JUMP_W = 25;
	localparam int unsigned SPACE_W = 21;
	localparam int unsigned CFG_W = 25;
	localparam int unsigned IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_STEP = 2'd0;
	localparam logic [IDX_W-1:0] REG_JUMP = 2'd1;
	localparam logic [IDX_W-1:0] REG_SPACE = 2'd2;

	localparam logic [STEP_W-1:0] STEP_RST = 21'd6554;
	localparam logic [JUMP_W-1:0] JUMP_RST = 25'd327680;
	localparam logic [SPACE_W-1:0] SPACE_RST = 21'd19661;

	localparam int unsigned MAX_STEPS = 64;
	localparam int unsigned K_W = $clog2(MAX_STEPS + 1);

	localparam int unsigned SQ_W = 64;
	localparam int unsigned ROOT_W = 32;
	localparam int unsigned LEN_W = 25;
	localparam int unsigned DIVN_W = 48;
	localparam int unsigned DIVD_W = 25;
	localparam int unsigned CNT_W = $clog2(DIVN_W + 1);

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD_FIRST,
		OP_LOAD_SEG,
		OP_CAP_SQ,
		OP_ADD_SQ,
		OP_SQRT_START,
		OP_CAP_LEN,
		OP_DIV_N,
		OP_CAP_N,
		OP_DIV_INC,
		OP_CAP_IX,
		OP_CAP_IY,
		OP_ADVANCE,
		OP_SET_INTERP,
		OP_DIFF,
		OP_DIST_SAT,
		OP_CAP_DIST,
		OP_ACC_KEEP,
		OP_ACC_EMIT,
		OP_FLUSH
	} op_t;

	typedef enum logic [2:0] {
		MS_MX,
		MS_MY,
		MS_JL,
		MS_MX_STEP,
		MS_MY_STEP,
		MS_DMX,
		MS_DMY
	} mul_sel_t;

	typedef struct packed {
		op_t      op;
		mul_sel_t mul;
	} cmd_t;

	typedef struct packed {
		logic have_prev;
		logic skip_big;
		logic seg_reject;
		logic sqrt_busy;
		logic div_busy;
		logic have_interp;
		logic k_zero;
		logic dsat;
		logic over;
		logic pend_valid;
		logic out_free;
	} stat_t;

endpackage

[hdl/prs_sqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
module prs_sqrt import prs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   val,
	output logic              busy,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] r_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W-1:0] trial;

	assign trial = r_q + bit_q;
	assign busy = |bit_q;
	assign root = r_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			r_q <= '0;
			bit_q <= '0;
		end else if (start) begin
			v_q <= val;
			r_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

[hdl/prs_div.sv]
// Restoring divider, one quotient bit per cycle.
module prs_div import prs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVN_W-1:0] dividend,
	input  logic [DIVD_W-1:0] divisor,
	output logic              busy,
	output logic [DIVN_W-1:0] quotient
);

	logic [DIVN_W-1:0] quo_q;
	logic [DIVD_W-1:0] rem_q;
	logic [DIVD_W-1:0] den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W:0]   shifted;
	logic [DIVD_W:0]   diff;
	logic              ge;

	assign shifted = {rem_q, quo_q[DIVN_W-1]};
	assign ge = shifted >= {1'b0, den_q};
	assign diff = shifted - {1'b0, den_q};
	assign busy = cnt_q != '0;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			cnt_q <= '0;
		end else if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
			cnt_q <= CNT_W'(DIVN_W);
		end else if (busy) begin
			rem_q <= ge ? diff[DIVD_W-1:0] : shifted[DIVD_W-1:0];
			quo_q <= {quo_q[DIVN_W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[hdl/prs_dpath.sv]
// Datapath: registers, shared multiplier, root and divide units, node output stage.
module prs_dpath import prs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  cmd_t                      cmd,
	output stat_t                     stat,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] node_x,
	output logic signed [COORD_W-1:0] node_y,
	output logic                      last_node
);

	function automatic logic [COORD_W:0] mag33(input logic [COORD_W:0] d);
		mag33 = d[COORD_W] ? (~d + 1'b1) : d;
	endfunction

	logic [STEP_W-1:0]  step_q;
	logic [JUMP_W-1:0]  jump_q;
	logic [SPACE_W-1:0] space_q;
	logic [STEP_W-1:0]  step_eff;

	logic [COORD_W-1:0] prev_x_q, prev_y_q, interp_x_q, interp_y_q;
	logic [COORD_W-1:0] cx_q, cy_q, ix_q, iy_q, pend_x_q, pend_y_q;
	logic [COORD_W-1:0] cum_q, dist_q, out_x_q, out_y_q;
	logic               have_prev_q, have_interp_q, pend_valid_q, out_valid_q, out_last_q;
	logic [COORD_W:0]   mx_q, my_q, dmx_q, dmy_q;
	logic               negx_q, negy_q;
	logic [SQ_W-1:0]    acc_q, prod_q;
	logic [LEN_W-1:0]   len_q;
	logic [K_W-1:0]     k_q;

	logic [COORD_W:0]   dx, dy, ddx, ddy;
	logic [COORD_W-1:0] mul_a, mul_b;
	logic [COORD_W:0]   cum_sum;
	logic [COORD_W-1:0] cum_sat;
	logic               push;

	logic               sqrt_busy, div_busy, div_start;
	logic [ROOT_W-1:0]  root;
	logic [DIVN_W-1:0]  div_dividend, div_quo;
	logic [DIVD_W-1:0]  div_divisor;

	assign step_eff = (step_q == '0) ? STEP_W'(1) : step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RST;
			jump_q <= JUMP_RST;
			space_q <= SPACE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP:  step_q <= cfg_data[STEP_W-1:0];
				REG_JUMP:  jump_q <= cfg_data[JUMP_W-1:0];
				REG_SPACE: space_q <= cfg_data[SPACE_W-1:0];
				default: ;
			endcase
		end
	end

	assign dx = {point_x[COORD_W-1], point_x} - {prev_x_q[COORD_W-1], prev_x_q};
	assign dy = {point_y[COORD_W-1], point_y} - {prev_y_q[COORD_W-1], prev_y_q};
	assign ddx = {cx_q[COORD_W-1], cx_q} - {interp_x_q[COORD_W-1], interp_x_q};
	assign ddy = {cy_q[COORD_W-1], cy_q} - {interp_y_q[COORD_W-1], interp_y_q};

	always_comb begin
		case (cmd.mul)
			MS_MX:      begin mul_a = mx_q[COORD_W-1:0];  mul_b = mx_q[COORD_W-1:0];  end
			MS_MY:      begin mul_a = my_q[COORD_W-1:0];  mul_b = my_q[COORD_W-1:0];  end
			MS_JL:      begin mul_a = COORD_W'(jump_q);   mul_b = COORD_W'(jump_q);   end
			MS_MX_STEP: begin mul_a = mx_q[COORD_W-1:0];  mul_b = COORD_W'(step_eff); end
			MS_MY_STEP: begin mul_a = my_q[COORD_W-1:0];  mul_b = COORD_W'(step_eff); end
			MS_DMX:     begin mul_a = dmx_q[COORD_W-1:0]; mul_b = dmx_q[COORD_W-1:0]; end
			MS_DMY:     begin mul_a = dmy_q[COORD_W-1:0]; mul_b = dmy_q[COORD_W-1:0]; end
			default:    begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign cum_sum = {1'b0, cum_q} + {1'b0, dist_q};
	assign cum_sat = cum_sum[COORD_W] ? '1 : cum_sum[COORD_W-1:0];

	assign div_start = (cmd.op == OP_DIV_N) || (cmd.op == OP_DIV_INC);
	assign div_dividend = (cmd.op == OP_DIV_N) ? DIVN_W'(len_q)
		: prod_q[DIVN_W-1:0] + DIVN_W'(len_q >> 1);
	assign div_divisor = (cmd.op == OP_DIV_N) ? DIVD_W'(step_eff) : DIVD_W'(len_q);

	prs_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_SQRT_START),
		.val    (acc_q),
		.busy   (sqrt_busy),
		.root   (root)
	);

	prs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// A held node goes out when a newer node replaces it or when the item ends.
	assign push = ((cmd.op == OP_ACC_EMIT) && pend_valid_q) || (cmd.op == OP_FLUSH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			have_prev_q <= 1'b0;
			interp_x_q <= '0;
			interp_y_q <= '0;
			have_interp_q <= 1'b0;
			cum_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD_FIRST: begin
					prev_x_q <= point_x;
					prev_y_q <= point_y;
					have_prev_q <= 1'b1;
					interp_x_q <= '0;
					interp_y_q <= '0;
					have_interp_q <= 1'b0;
					cum_q <= '0;
				end
				OP_LOAD_SEG: begin
					prev_x_q <= point_x;
					prev_y_q <= point_y;
				end
				OP_SET_INTERP: begin
					interp_x_q <= cx_q;
					interp_y_q <= cy_q;
					have_interp_q <= 1'b1;
				end
				OP_ACC_KEEP: cum_q <= cum_sat;
				OP_ACC_EMIT: begin
					cum_q <= '0;
					pend_valid_q <= 1'b1;
				end
				OP_FLUSH: pend_valid_q <= 1'b0;
				default: ;
			endcase
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD_SEG: begin
				cx_q <= prev_x_q;
				cy_q <= prev_y_q;
				mx_q <= mag33(dx);
				my_q <= mag33(dy);
				negx_q <= dx[COORD_W];
				negy_q <= dy[COORD_W];
			end
			OP_CAP_SQ:   acc_q <= prod_q;
			OP_ADD_SQ:   acc_q <= acc_q + prod_q;
			OP_CAP_LEN:  len_q <= root[LEN_W-1:0];
			OP_CAP_N: begin
				if (div_quo > DIVN_W'(MAX_STEPS)) begin
					k_q <= K_W'(MAX_STEPS);
				end else if (div_quo == '0) begin
					k_q <= K_W'(1);
				end else begin
					k_q <= div_quo[K_W-1:0];
				end
			end
			OP_CAP_IX: ix_q <= negx_q ? ('0 - div_quo[COORD_W-1:0]) : div_quo[COORD_W-1:0];
			OP_CAP_IY: iy_q <= negy_q ? ('0 - div_quo[COORD_W-1:0]) : div_quo[COORD_W-1:0];
			OP_ADVANCE: begin
				cx_q <= cx_q + ix_q;
				cy_q <= cy_q + iy_q;
				k_q <= k_q - 1'b1;
			end
			OP_DIFF: begin
				dmx_q <= mag33(ddx);
				dmy_q <= mag33(ddy);
			end
			OP_DIST_SAT: dist_q <= '1;
			OP_CAP_DIST: dist_q <= root;
			OP_ACC_EMIT: begin
				pend_x_q <= interp_x_q;
				pend_y_q <= interp_y_q;
			end
			default: ;
		endcase
		if (push) begin
			out_x_q <= pend_x_q;
			out_y_q <= pend_y_q;
			out_last_q <= (cmd.op == OP_FLUSH);
		end
	end

	assign stat.have_prev = have_prev_q;
	assign stat.skip_big = (mx_q > (COORD_W + 1)'(jump_q)) || (my_q > (COORD_W + 1)'(jump_q));
	assign stat.seg_reject = (acc_q == '0) || (acc_q > prod_q);
	assign stat.sqrt_busy = sqrt_busy;
	assign stat.div_busy = div_busy;
	assign stat.have_interp = have_interp_q;
	assign stat.k_zero = k_q == '0;
	assign stat.dsat = (dmx_q[COORD_W:COORD_W-1] != 2'b00)
		|| (dmy_q[COORD_W:COORD_W-1] != 2'b00);
	assign stat.over = cum_sat > COORD_W'(space_q);
	assign stat.pend_valid = pend_valid_q;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign node_x = out_x_q;
	assign node_y = out_y_q;
	assign last_node = out_last_q;

endmodule

[hdl/prs_ctrl.sv]
// Controller state machine that sequences the datapath for one point at a time.
module prs_ctrl import prs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  start_trail,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHECK, ST_SQX, ST_SQY, ST_JL, ST_LEN, ST_DIVN, ST_WAITN,
		ST_DIVX, ST_WAITX, ST_DIVY, ST_WAITY, ST_STEP, ST_DIFF, ST_DSQ, ST_DSQX,
		ST_DSQY, ST_DSQRT, ST_DWAIT, ST_ACC, ST_NEXT, ST_FLUSH
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		cmd.mul = MS_MX;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (start_trail || !stat.have_prev) begin
						cmd.op = OP_LOAD_FIRST;
					end else begin
						cmd.op = OP_LOAD_SEG;
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (stat.skip_big) begin
					state_d = ST_IDLE;
				end else begin
					cmd.mul = MS_MX;
					state_d = ST_SQX;
				end
			end
			ST_SQX: begin
				cmd.op = OP_CAP_SQ;
				cmd.mul = MS_MY;
				state_d = ST_SQY;
			end
			ST_SQY: begin
				cmd.op = OP_ADD_SQ;
				cmd.mul = MS_JL;
				state_d = ST_JL;
			end
			ST_JL: begin
				if (stat.seg_reject) begin
					state_d = ST_IDLE;
				end else begin
					cmd.op = OP_SQRT_START;
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				if (!stat.sqrt_busy) begin
					cmd.op = OP_CAP_LEN;
					state_d = ST_DIVN;
				end
			end
			ST_DIVN: begin
				cmd.op = OP_DIV_N;
				state_d = ST_WAITN;
			end
			ST_WAITN: begin
				if (!stat.div_busy) begin
					cmd.op = OP_CAP_N;
					cmd.mul = MS_MX_STEP;
					state_d = ST_DIVX;
				end
			end
			ST_DIVX: begin
				cmd.op = OP_DIV_INC;
				state_d = ST_WAITX;
			end
			ST_WAITX: begin
				if (!stat.div_busy) begin
					cmd.op = OP_CAP_IX;
					cmd.mul = MS_MY_STEP;
					state_d = ST_DIVY;
				end
			end
			ST_DIVY: begin
				cmd.op = OP_DIV_INC;
				state_d = ST_WAITY;
			end
			ST_WAITY: begin
				if (!stat.div_busy) begin
					cmd.op = OP_CAP_IY;
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.op = OP_ADVANCE;
				state_d = stat.have_interp ? ST_DIFF : ST_NEXT;
			end
			ST_DIFF: begin
				cmd.op = OP_DIFF;
				state_d = ST_DSQ;
			end
			ST_DSQ: begin
				if (stat.dsat) begin
					cmd.op = OP_DIST_SAT;
					state_d = ST_ACC;
				end else begin
					cmd.mul = MS_DMX;
					state_d = ST_DSQX;
				end
			end
			ST_DSQX: begin
				cmd.op = OP_CAP_SQ;
				cmd.mul = MS_DMY;
				state_d = ST_DSQY;
			end
			ST_DSQY: begin
				cmd.op = OP_ADD_SQ;
				state_d = ST_DSQRT;
			end
			ST_DSQRT: begin
				cmd.op = OP_SQRT_START;
				state_d = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (!stat.sqrt_busy) begin
					cmd.op = OP_CAP_DIST;
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				if (!stat.over) begin
					cmd.op = OP_ACC_KEEP;
					state_d = ST_NEXT;
				end else if (!stat.pend_valid || stat.out_free) begin
					cmd.op = OP_ACC_EMIT;
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				cmd.op = OP_SET_INTERP;
				state_d = stat.k_zero ? ST_FLUSH : ST_STEP;
			end
			ST_FLUSH: begin
				if (!stat.pend_valid) begin
					state_d = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.op = OP_FLUSH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/polyline_resample_simplify.sv]
// Top level of the fixed-step polyline resampler and node simplifier.
//
//  Channel  Signals                                   Direction  Beat
//  in       in_valid/in_ready, point_x/y, start_trail  sink       one path point
//  out      out_valid/out_ready, node_x/y, last_node   source     one emitted node
//  cfg      cfg_we, cfg_index, cfg_data               sink       one register write
//
// A point that starts a trail only loads the first point. A segment is dropped when it is
// too long on one axis or, on the squared test, of zero length or over long. A kept
// segment runs one root and three divisions, then per placed point a neighbor root
// (none for the first point of a trail or a saturated distance), at most 64 points,
// and a closing flush state. Reset is asynchronous,
// active low, and restores the register defaults. Two nodes may wait, one held and
// one in the output register; a stalled output holds the block only beyond that.
module polyline_resample_simplify import prs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic                      start_trail,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] node_x,
	output logic signed [COORD_W-1:0] node_y,
	output logic                      last_node
);

	// The controller needs to know whether a previous point is held; the
	// datapath tracks it and it travels with the other status.
	cmd_t  cmd;
	stat_t stat;

	prs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.start_trail (start_trail),
		.in_ready    (in_ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	prs_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.point_x   (point_x),
		.point_y   (point_y),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.node_x    (node_x),
		.node_y    (node_y),
		.last_node (last_node)
	);

endmodule

[hdl/prs_checker.sv]
// Port-level checker for the resampler, bound to the top level.
module prs_checker import prs_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      start_trail,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [COORD_W-1:0] node_x,
	input logic signed [COORD_W-1:0] node_y,
	input logic                      last_node
);

	// A stalled node beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(node_x) && $stable(node_y)
			&& $stable(last_node))
		else $error("output beat changed while stalled");

	// Starting a trail never produces a node.
	a_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && start_trail && !out_valid |=> !out_valid)
		else $error("node emitted for a trail start");

	// A trail start does not hold the input; the block is ready again in the next cycle.
	a_start_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && start_trail |=> in_ready)
		else $error("trail start held the input");

endmodule

bind polyline_resample_simplify prs_checker u_prs_checker (.*);
